// ----- hdl/cars_pkg.sv -----
// Shared constants for the conflict-aware rule scheduler.
// Holds field widths, register indexes and parameter defaults; no dependencies.
`default_nettype none

package cars_pkg;

    // Parameter defaults.
    localparam int NUM_RULES_DEFAULT = 8;
    localparam int RANK_BITS_DEFAULT = 4;

    // Payload field widths.
    localparam int ENABLED_W = 8;
    localparam int FIRED_W   = 8;
    localparam int COUNT_W   = 4;
    localparam int BEST_W    = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Configuration register widths.
    localparam int RANKS_W     = 32;
    localparam int CONFLICT_W  = 64;
    localparam int CONFLICT_STRIDE = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RULE_RANKS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFLICT_MATRIX = 2'd2;

    // Policy modes.
    localparam logic POLICY_GREEDY = 1'b0;
    localparam logic POLICY_SINGLE = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/conflict_aware_rule_scheduler.sv -----
// Each input transfer loads the input register; the result register loads from it
// through the selection logic whenever it moves. Throughput: one item per cycle
// unless the result stalls, set by the single pass through the selection logic;
// a stalled result holds one more item in the input register.
// Ranks take effect once the visit-order table has reloaded from the written ranks.
// Reset (aresetn, synchronous, active low) empties both stages and clears the config.
`default_nettype none

module conflict_aware_rule_scheduler #(
    parameter int NUM_RULES = cars_pkg::NUM_RULES_DEFAULT,
    parameter int RANK_BITS = cars_pkg::RANK_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [cars_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] enabled_mask
    // Result stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] fired_mask, [11:8] fired_count, [14:12] best_index, [15] any_fired
    output logic [cars_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // Configuration writes.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cars_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cars_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cars_pkg::*;

    logic                                policy_mode;
    logic [NUM_RULES-1:0][NUM_RULES-1:0] prec;
    logic [NUM_RULES-1:0][NUM_RULES-1:0] conf;

    logic                 in_valid_reg;
    logic [NUM_RULES-1:0] in_mask_reg;
    logic                 out_valid_reg;
    logic [FIRED_W-1:0]   fired_mask_reg;
    logic [COUNT_W-1:0]   fired_count_reg;
    logic [BEST_W-1:0]    best_index_reg;
    logic                 any_fired_reg;

    logic [FIRED_W-1:0]   fired_mask_next;
    logic [COUNT_W-1:0]   fired_count_next;
    logic [BEST_W-1:0]    best_index_next;
    logic                 any_fired_next;
    logic                 advance;

    cars_cfg #(
        .NUM_RULES (NUM_RULES),
        .RANK_BITS (RANK_BITS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .policy_mode (policy_mode),
        .prec        (prec),
        .conf        (conf)
    );

    cars_select #(
        .NUM_RULES (NUM_RULES)
    ) u_select (
        .policy_mode (policy_mode),
        .enabled     (in_mask_reg),
        .prec        (prec),
        .conf        (conf),
        .fired_mask  (fired_mask_next),
        .fired_count (fired_count_next),
        .best_index  (best_index_next),
        .any_fired   (any_fired_next)
    );

    // The result register moves when it is empty or its transfer completes.
    // Nothing is taken in while reset is held.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = aresetn && (!in_valid_reg || advance);
    assign cfg_ready = aresetn;

    // Pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers; enable bits above the rule count are dropped here.
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_mask_reg <= s_tdata[NUM_RULES-1:0];
        end
        if (advance) begin
            fired_mask_reg  <= fired_mask_next;
            fired_count_reg <= fired_count_next;
            best_index_reg  <= best_index_next;
            any_fired_reg   <= any_fired_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {any_fired_reg, best_index_reg, fired_count_reg, fired_mask_reg};

endmodule

`default_nettype wire

// ----- hdl/cars_cfg.sv -----
// Configuration registers of the rule scheduler and the tables derived from them.
// Depends on cars_pkg for widths and register indexes.
`default_nettype none

module cars_cfg #(
    parameter int NUM_RULES = cars_pkg::NUM_RULES_DEFAULT,
    parameter int RANK_BITS = cars_pkg::RANK_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [cars_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cars_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  policy_mode,
    // prec[i][j] is set when rule j is visited ahead of rule i.
    output logic [NUM_RULES-1:0][NUM_RULES-1:0]   prec,
    // conf[i][j] is set when rules i and j conflict in either direction.
    output logic [NUM_RULES-1:0][NUM_RULES-1:0]   conf
);
    import cars_pkg::*;

    localparam int RANK_EXT_W = RANKS_W + NUM_RULES * RANK_BITS;

    logic                                policy_mode_reg;
    logic [RANKS_W-1:0]                  rule_ranks_reg;
    logic [CONFLICT_W-1:0]               conflict_matrix_reg;
    logic [NUM_RULES-1:0][NUM_RULES-1:0] prec_reg;
    logic [NUM_RULES-1:0][NUM_RULES-1:0] prec_next;
    logic [RANK_EXT_W-1:0]               ranks_ext;
    logic [RANK_BITS-1:0]                rank [NUM_RULES];

    // Register writes; an index past the last register is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_mode_reg     <= POLICY_GREEDY;
            rule_ranks_reg      <= '0;
            conflict_matrix_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_POLICY_MODE:     policy_mode_reg     <= cfg_data[0];
                CFG_RULE_RANKS:      rule_ranks_reg      <= cfg_data[RANKS_W-1:0];
                CFG_CONFLICT_MATRIX: conflict_matrix_reg <= cfg_data[CONFLICT_W-1:0];
                default: ;
            endcase
        end
    end

    // Rank fields that reach past the register read as zero.
    assign ranks_ext = {{(NUM_RULES * RANK_BITS){1'b0}}, rule_ranks_reg};

    always_comb begin
        for (int i = 0; i < NUM_RULES; i++) begin
            rank[i] = ranks_ext[i*RANK_BITS +: RANK_BITS];
        end
    end

    // Visit order: lower rank first, lower index first among equal ranks.
    always_comb begin
        for (int i = 0; i < NUM_RULES; i++) begin
            for (int j = 0; j < NUM_RULES; j++) begin
                prec_next[i][j] = (rank[j] < rank[i]) || ((rank[j] == rank[i]) && (j < i));
            end
        end
    end

    // The order only changes on a ranks write, so it is held in a register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prec_reg <= '0;
        end else begin
            prec_reg <= prec_next;
        end
    end

    // Conflicts are symmetric: either matrix bit of a pair suffices.
    always_comb begin
        for (int a = 0; a < NUM_RULES; a++) begin
            for (int b = 0; b < NUM_RULES; b++) begin
                conf[a][b] = conflict_matrix_reg[a*CONFLICT_STRIDE + b]
                           | conflict_matrix_reg[b*CONFLICT_STRIDE + a];
            end
        end
    end

    assign policy_mode = policy_mode_reg;
    assign prec        = prec_reg;

endmodule

`default_nettype wire

// ----- hdl/cars_select.sv -----
// Selection logic of the rule scheduler, greedy or single mode: one pass over the visit order.
// Depends on cars_pkg for output field widths and policy codes.
`default_nettype none

module cars_select #(
    parameter int NUM_RULES = cars_pkg::NUM_RULES_DEFAULT
) (
    input  wire logic                                policy_mode,
    input  wire logic [NUM_RULES-1:0]                enabled,
    input  wire logic [NUM_RULES-1:0][NUM_RULES-1:0] prec,
    input  wire logic [NUM_RULES-1:0][NUM_RULES-1:0] conf,
    output logic [cars_pkg::FIRED_W-1:0]             fired_mask,
    output logic [cars_pkg::COUNT_W-1:0]             fired_count,
    output logic [cars_pkg::BEST_W-1:0]              best_index,
    output logic                                     any_fired
);
    import cars_pkg::*;

    localparam int POS_W = $clog2(NUM_RULES);

    logic [POS_W-1:0]     pos [NUM_RULES];
    logic [NUM_RULES-1:0] fired;

    // Place of each enabled rule in the visit order: count of enabled rules ahead.
    always_comb begin
        for (int i = 0; i < NUM_RULES; i++) begin
            pos[i] = '0;
            for (int j = 0; j < NUM_RULES; j++) begin
                if (enabled[j] && prec[i][j]) begin
                    pos[i] = pos[i] + POS_W'(1);
                end
            end
        end
    end

    // Walk the order one place at a time; a rule fires unless it conflicts
    // with one already chosen. In single mode only the first place fires.
    always_comb begin
        logic [NUM_RULES-1:0] hit;
        logic                 blocked;
        fired = '0;
        for (int p = 0; p < NUM_RULES; p++) begin
            hit     = '0;
            blocked = 1'b0;
            for (int i = 0; i < NUM_RULES; i++) begin
                hit[i] = enabled[i] && (pos[i] == POS_W'(p));
            end
            for (int i = 0; i < NUM_RULES; i++) begin
                if (hit[i] && |(fired & conf[i])) begin
                    blocked = 1'b1;
                end
            end
            if ((policy_mode == POLICY_GREEDY || p == 0) && !blocked) begin
                fired = fired | hit;
            end
        end
    end

    // Count of fired rules and the first rule in the visit order.
    always_comb begin
        fired_count = '0;
        best_index  = '0;
        for (int i = 0; i < NUM_RULES; i++) begin
            fired_count = fired_count + COUNT_W'(fired[i]);
            if (enabled[i] && pos[i] == '0) begin
                best_index = BEST_W'(i);
            end
        end
    end

    assign fired_mask = FIRED_W'(fired);
    assign any_fired  = |fired;

endmodule

`default_nettype wire

// ----- hdl/cars_checker.sv -----
// Port-level assertions for the rule scheduler, bound to the top level.
// Depends on cars_pkg for stream widths.
`default_nettype none

module cars_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [cars_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import cars_pkg::*;

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The count agrees with the fired set, and any_fired with the count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones(m_tdata[7:0]) == m_tdata[11:8])
                     && (m_tdata[15] == (m_tdata[11:8] != 4'd0)))
        else $error("fired count or flag disagrees with fired mask");

    // The first visited rule always fires; with nothing fired the index is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15] ? m_tdata[m_tdata[14:12]] : (m_tdata[14:12] == 3'd0)))
        else $error("best rule missing from fired set");

    // An item entering an empty pipeline is offered once it has passed the input and result registers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result not offered after two cycles");

endmodule

bind conflict_aware_rule_scheduler cars_checker u_cars_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- verif/conflict_aware_rule_scheduler_tb.sv -----
// Self-checking testbench for the conflict-aware rule scheduler.
// Depends on cars_pkg and the conflict_aware_rule_scheduler RTL only.
`timescale 1ns / 1ps

module conflict_aware_rule_scheduler_tb;
    import cars_pkg::*;

    localparam int NRULES  = NUM_RULES_DEFAULT;
    localparam int RANK_W  = RANK_BITS_DEFAULT;
    localparam int NRANKS  = 1 << RANK_W;
    localparam int RANDOM_PHASES  = 12;
    localparam int ITEMS_PER_PHASE = 74;

    // One result item as it travels on m_tdata, highest field first.
    typedef struct packed {
        logic               any_fired;
        logic [BEST_W-1:0]  best_index;
        logic [COUNT_W-1:0] fired_count;
        logic [FIRED_W-1:0] fired_mask;
    } firing_t;

    // Scoreboard: a private copy of the registers, the selection predictor and
    // the queue of firing sets still owed by the block.
    class firing_scoreboard_t;
        logic                  policy;
        logic [RANKS_W-1:0]    ranks;
        logic [CONFLICT_W-1:0] conflicts;
        firing_t               expected_firings[$];
        int unsigned           errors;
        int unsigned           matched;

        function new();
            policy    = POLICY_GREEDY;
            ranks     = '0;
            conflicts = '0;
            errors    = 0;
            matched   = 0;
        endfunction

        // Mirror of a register write; bits above a register's width drop off.
        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_POLICY_MODE:     policy = value[0];
                CFG_RULE_RANKS:      ranks = value[RANKS_W-1:0];
                CFG_CONFLICT_MATRIX: conflicts = value[CONFLICT_W-1:0];
                default: ;
            endcase
        endfunction

        // Visit rules by rank, then by index, and build the firing set.
        function firing_t predict_firing(logic [ENABLED_W-1:0] enabled);
            firing_t res;
            bit      have_best;
            bit      clear;
            int      r;
            int      i;
            int      j;
            res = '0;
            have_best = 0;
            for (r = 0; r < NRANKS; r++) begin
                for (i = 0; i < NRULES; i++) begin
                    if (enabled[i] && ranks[i*RANK_W +: RANK_W] == r) begin
                        if (!have_best) begin
                            have_best = 1;
                            res.best_index = BEST_W'(i);
                        end
                        if (policy == POLICY_SINGLE) begin
                            if (res.fired_count == 0) begin
                                res.fired_mask[i] = 1'b1;
                                res.fired_count = COUNT_W'(1);
                            end
                        end else begin
                            // The conflict relation is symmetric: either bit counts.
                            clear = 1;
                            for (j = 0; j < NRULES; j++) begin
                                if (res.fired_mask[j] &&
                                    (conflicts[i*CONFLICT_STRIDE + j] ||
                                     conflicts[j*CONFLICT_STRIDE + i]))
                                    clear = 0;
                            end
                            if (clear) begin
                                res.fired_mask[i] = 1'b1;
                                res.fired_count = res.fired_count + COUNT_W'(1);
                            end
                        end
                    end
                end
            end
            res.any_fired = (res.fired_count != 0);
            return res;
        endfunction

        function void note_input(logic [ENABLED_W-1:0] enabled);
            expected_firings = {expected_firings, predict_firing(enabled)};
        endfunction

        task report_mismatch(string what, int unsigned want, int unsigned got);
            if (errors < 50)
                $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $realtime, what,
                         want, got);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data);
            firing_t got;
            firing_t want;
            got = data;
            if (expected_firings.size() == 0) begin
                report_mismatch("result with nothing outstanding", 0, data);
            end else begin
                want = expected_firings.pop_front();
                if (got.fired_mask !== want.fired_mask)
                    report_mismatch("fired_mask", want.fired_mask, got.fired_mask);
                if (got.fired_count !== want.fired_count)
                    report_mismatch("fired_count", want.fired_count, got.fired_count);
                if (got.best_index !== want.best_index)
                    report_mismatch("best_index", want.best_index, got.best_index);
                if (got.any_fired !== want.any_fired)
                    report_mismatch("any_fired", want.any_fired, got.any_fired);
                matched++;
            end
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [7:0] enabled_mask
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [7:0] fired_mask, [11:8] fired_count,
                                       // [14:12] best_index, [15] any_fired
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    firing_scoreboard_t board;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned hold_cycles;
    int unsigned settings_seen;

    conflict_aware_rule_scheduler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous upper bound on the whole run.
    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

    // Offer one enabled vector and hold it until the transfer happens.
    // Called and returning at a falling edge.
    task automatic send_item(input logic [ENABLED_W-1:0] enabled);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tdata  <= enabled;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_input(enabled);
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        while (board.expected_firings.size() != 0) @(negedge aclk);
    endtask

    // Left with cfg_valid high so back-to-back writes never toggle it in one step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, value);
        @(negedge aclk);
    endtask

    // Registers change only with the block empty.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] policy_word,
                                  input logic [CFG_DATA_W-1:0] ranks_word,
                                  input logic [CFG_DATA_W-1:0] conflict_word);
        s_tvalid <= 1'b0;
        wait_drain();
        repeat (4) @(negedge aclk);
        write_reg(CFG_POLICY_MODE, policy_word);
        write_reg(CFG_RULE_RANKS, ranks_word);
        write_reg(CFG_CONFLICT_MATRIX, conflict_word);
        cfg_valid <= 1'b0;
        // The visit-order table reloads the cycle after a rank write.
        repeat (3) @(negedge aclk);
        settings_seen++;
    endtask

    // Result side: check each transfer, then pick the next ready level.
    initial begin : result_side
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_result(m_tdata);
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned            phase;
        int unsigned            n;
        int                     a;
        int                     b;
        logic [CFG_DATA_W-1:0]  ranks_word;
        logic [CFG_DATA_W-1:0]  conflict_word;
        logic [CFG_DATA_W-1:0]  triangle;
        logic [ENABLED_W-1:0]   enabled;

        board = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        hold_cycles   = 0;
        settings_seen = 0;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset values: greedy, all ranks tied, no conflicts.
        send_item(8'h00);
        send_item(8'hFF);
        send_item(8'h01);

        // Single mode with junk above bit 0; reversed ranks put rule 7 first.
        apply_settings({32'hDEADBEEF, 31'h0, POLICY_SINGLE}, 64'h0000_0000_0123_4567, '0);
        send_item(8'hFF);
        send_item(8'h00);
        send_item(8'h81);

        // Every pair conflicts and all ranks are at the maximum.
        apply_settings({63'h0, POLICY_GREEDY}, 64'hFFFF_FFFF_FFFF_FFFF, '1);
        send_item(8'hFF);
        send_item(8'h80);

        // Only diagonal bits set: they must not block anything.
        apply_settings({63'h0, POLICY_GREEDY}, 64'hA5A5_A5A5_0F0F_0F0F,
                       64'h8040_2010_0804_0201);
        send_item(8'hFF);
        send_item(8'hAA);

        // One-sided conflicts, first in rule 0's row and then in its column.
        apply_settings({63'h0, POLICY_GREEDY}, 64'h0000_0000_7654_3210, 64'h0000_0000_0000_00FE);
        send_item(8'hFF);
        send_item(8'hFE);
        send_item(8'h55);
        apply_settings({63'h0, POLICY_GREEDY}, 64'h0000_0000_7654_3210, 64'h0101_0101_0101_0100);
        send_item(8'hFF);
        send_item(8'h03);
        send_item(8'h7F);

        // Random settings, each followed by a run of random enabled vectors.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       ranks_word = {$urandom, 32'h0};
                1:       ranks_word = {$urandom, 32'hFFFF_FFFF};
                2: begin
                    // Few distinct ranks, so ties are common.
                    ranks_word = {$urandom, 32'h0};
                    for (a = 0; a < NRULES; a++)
                        ranks_word[a*RANK_W +: RANK_W] = RANK_W'($urandom_range(0, 2));
                end
                default: ranks_word = {$urandom, $urandom};
            endcase
            triangle = '0;
            for (a = 0; a < NRULES; a++)
                for (b = a + 1; b < NRULES; b++)
                    triangle[a*CONFLICT_STRIDE + b] = 1'b1;
            case ($urandom_range(0, 5))
                0:       conflict_word = '0;
                1:       conflict_word = '1;
                2:       conflict_word = {$urandom, $urandom} & {$urandom, $urandom}
                                         & {$urandom, $urandom};
                3:       conflict_word = {$urandom, $urandom} & triangle;
                4:       conflict_word = {$urandom, $urandom} & ~triangle;
                default: conflict_word = {$urandom, $urandom};
            endcase
            apply_settings({$urandom, $urandom}, ranks_word, conflict_word);

            // The final phase runs with no idling on either side.
            tx_idle_on = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (phase == 4) begin
                // Long receiver hold-off while the sender keeps offering.
                tx_idle_on  = 1'b0;
                hold_cycles = 80;
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 3))
                    0:       enabled = ENABLED_W'($urandom & $urandom);
                    1:       enabled = ENABLED_W'($urandom | $urandom);
                    default: enabled = ENABLED_W'($urandom_range(0, 255));
                endcase
                if (phase == 7 && n == 30) begin
                    // Sender pause until every owed result has come back.
                    s_tvalid <= 1'b0;
                    wait_drain();
                    @(negedge aclk);
                end
                send_item(enabled);
            end
        end

        s_tvalid <= 1'b0;
        wait_drain();
        repeat (8) @(negedge aclk);
        if (board.expected_firings.size() != 0)
            board.report_mismatch("results still owed at end", 0,
                                  board.expected_firings.size());

        $display("Checked %0d firing sets under %0d register settings.", board.matched,
                 settings_seen + 1);
        $display("Covered greedy and single-rule modes, tied ranks, full, diagonal and ",
                 "one-sided conflicts, receiver hold-off and sender drain.");
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
